// ===== rtl/core/slst_pkg.sv =====
package slst_pkg;

  // Store geometry.
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  // Command kinds carried by an input word.
  localparam logic [1:0] KIND_INSERT    = 2'd0;
  localparam logic [1:0] KIND_REMOVE    = 2'd1;
  localparam logic [1:0] KIND_NEIGHBOUR = 2'd2;
  localparam logic [1:0] KIND_LIST      = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  // What one cell does at the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_cmd_e;

  // What the whole chain does at the next clock edge.
  typedef enum logic [1:0] {
    CH_HOLD   = 2'd0,
    CH_INSERT = 2'd1,
    CH_DELETE = 2'd2,
    CH_ROTATE = 2'd3
  } chain_op_e;

  typedef struct packed {
    chain_op_e        op;
    logic [IDX_W-1:0] idx;
  } chain_cmd_t;

  typedef struct packed {
    logic [DEPTH-1:0] lt;
    logic [DEPTH-1:0] eq;
  } chain_flags_t;

endpackage

// ===== rtl/core/slst_cell.sv =====
module slst_cell (
  input  logic                             clk_i,
  input  slst_pkg::cell_cmd_e              cmd_i,
  input  logic signed [slst_pkg::DATA_W-1:0] left_i,
  input  logic signed [slst_pkg::DATA_W-1:0] right_i,
  input  logic signed [slst_pkg::DATA_W-1:0] operand_i,
  input  logic                             valid_i,
  output logic signed [slst_pkg::DATA_W-1:0] value_o,
  output logic                             lt_o,
  output logic                             eq_o
);
  import slst_pkg::*;

  logic signed [DATA_W-1:0] value_q;
  logic signed [DATA_W-1:0] value_d;

  // Select the new content of this cell.
  always_comb begin
    case (cmd_i)
      CELL_LOAD:  value_d = operand_i;
      CELL_LEFT:  value_d = left_i;
      CELL_RIGHT: value_d = right_i;
      default:    value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // Local compares against the operand, qualified by occupancy.
  assign lt_o    = valid_i && (value_q < operand_i);
  assign eq_o    = valid_i && (value_q == operand_i);
  assign value_o = value_q;

endmodule

// ===== rtl/core/slst_chain.sv =====
module slst_chain (
  input  logic                               clk_i,
  input  slst_pkg::chain_cmd_t               cmd_i,
  input  logic signed [slst_pkg::DATA_W-1:0] operand_i,
  input  logic [slst_pkg::CNT_W-1:0]         count_i,
  output slst_pkg::chain_flags_t             flags_o,
  output logic signed [slst_pkg::DATA_W-1:0] head_o
);
  import slst_pkg::*;

  logic signed [DATA_W-1:0] value [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    cell_cmd_e                cmd;
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;

    // The first cell sees the operand on its left; the last cell wraps to the head.
    if (k == 0) begin : g_first
      assign left = operand_i;
    end else begin : g_mid_l
      assign left = value[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right = value[0];
    end else begin : g_mid_r
      assign right = value[k+1];
    end

    // Decode the chain command into this cell's action.
    always_comb begin
      case (cmd_i.op)
        CH_INSERT: begin
          if (IDX_W'(k) < cmd_i.idx) begin
            cmd = CELL_HOLD;
          end else if (IDX_W'(k) == cmd_i.idx) begin
            cmd = CELL_LOAD;
          end else begin
            cmd = CELL_LEFT;
          end
        end
        CH_DELETE: begin
          if (IDX_W'(k) < cmd_i.idx || k == DEPTH - 1) begin
            cmd = CELL_HOLD;
          end else begin
            cmd = CELL_RIGHT;
          end
        end
        CH_ROTATE: cmd = CELL_RIGHT;
        default:   cmd = CELL_HOLD;
      endcase
    end

    slst_cell u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .left_i    (left),
      .right_i   (right),
      .operand_i (operand_i),
      .valid_i   (CNT_W'(k) < count_i),
      .value_o   (value[k]),
      .lt_o      (flags_o.lt[k]),
      .eq_o      (flags_o.eq[k])
    );
  end

  assign head_o = value[0];

endmodule

// ===== rtl/core/sorted_list_engine.sv =====
// Sorted list engine: a row of 16 cells keeps signed 32-bit values in ascending
// order; each cell compares its value with the operand and shifts toward a neighbor.
// A command word is taken when start is high and busy is low. Insert and remove give
// a single result, and busy is already low while it is shown, so the next word can
// be taken in that cycle. Remove-neighbours walks the cells one position per cycle,
// pausing on each matching entry to drop its successor; deleted successors are never
// examined. List rotates the whole row once through the head cell, keeping busy high
// throughout; it gives one result per held entry on consecutive cycles. Each result
// is shown for one cycle with done_o high and cannot be held off; the last result of
// a command carries last_o.
module sorted_list_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         kind_i,
  input  logic signed [slst_pkg::DATA_W-1:0] operand_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic signed [slst_pkg::DATA_W-1:0] entry_value_o,
  output logic [slst_pkg::IDX_W-1:0]         position_o,
  output logic [slst_pkg::CNT_W-1:0]         held_o,
  output logic [slst_pkg::CNT_W-1:0]         removed_o,
  output logic                               last_o
);
  import slst_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_WALK = 5'b00100,
    ST_SUCC = 5'b01000,
    ST_LIST = 5'b10000
  } state_e;

  state_e                   state_q, state_d;
  logic [1:0]               kind_q;
  logic signed [DATA_W-1:0] op_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         i_q, i_d;
  logic [CNT_W-1:0]         rem_q, rem_d;
  logic                     match_q, match_d;

  logic                     res_d;
  logic [1:0]               status_d;
  logic signed [DATA_W-1:0] value_d;
  logic [IDX_W-1:0]         pos_d;
  logic [CNT_W-1:0]         held_d;
  logic [CNT_W-1:0]         removed_d;
  logic                     last_d;

  chain_cmd_t               cmd;
  chain_flags_t             flags;
  logic signed [DATA_W-1:0] head;
  logic [IDX_W-1:0]         ins_idx;
  logic [IDX_W-1:0]         eq_idx;
  logic                     any_eq;

  logic                     accept;
  logic [IDX_W-1:0]         i_idx;
  logic [CNT_W-1:0]         i_inc;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign i_idx  = i_q[IDX_W-1:0];
  assign i_inc  = i_q + CNT_W'(1);

  slst_chain u_chain (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .operand_i (op_q),
    .count_i   (count_q),
    .flags_o   (flags),
    .head_o    (head)
  );

  // Insert point is the first cell not below the operand; remove point the first match.
  always_comb begin
    ins_idx = IDX_W'(count_q);
    eq_idx  = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (!flags.lt[k]) begin
        ins_idx = IDX_W'(k);
      end
      if (flags.eq[k]) begin
        eq_idx = IDX_W'(k);
      end
    end
  end
  assign any_eq = |flags.eq;

  // Sequencer for all command kinds.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    i_d       = i_q;
    rem_d     = rem_q;
    match_d   = match_q;
    cmd.op    = CH_HOLD;
    cmd.idx   = '0;
    res_d     = 1'b0;
    status_d  = STAT_OK;
    value_d   = op_q;
    pos_d     = '0;
    held_d    = count_q;
    removed_d = '0;
    last_d    = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_IDLE;
        i_d     = '0;
        rem_d   = '0;
        match_d = 1'b0;
        case (kind_q)
          KIND_INSERT: begin
            res_d = 1'b1;
            if (count_q == CNT_W'(DEPTH)) begin
              status_d = STAT_FULL;
            end else begin
              cmd.op  = CH_INSERT;
              cmd.idx = ins_idx;
              pos_d   = ins_idx;
              count_d = count_q + CNT_W'(1);
              held_d  = count_q + CNT_W'(1);
            end
          end
          KIND_REMOVE: begin
            res_d = 1'b1;
            if (count_q == '0) begin
              status_d = STAT_EMPTY;
            end else if (!any_eq) begin
              status_d = STAT_NOT_FOUND;
            end else begin
              cmd.op    = CH_DELETE;
              cmd.idx   = eq_idx;
              pos_d     = eq_idx;
              count_d   = count_q - CNT_W'(1);
              held_d    = count_q - CNT_W'(1);
              removed_d = CNT_W'(1);
            end
          end
          KIND_NEIGHBOUR: begin
            if (count_q == '0) begin
              res_d    = 1'b1;
              status_d = STAT_EMPTY;
            end else begin
              state_d = ST_WALK;
            end
          end
          default: begin
            if (count_q == '0) begin
              res_d    = 1'b1;
              status_d = STAT_EMPTY;
              value_d  = '0;
            end else begin
              state_d = ST_LIST;
            end
          end
        endcase
      end

      // Examine one position; on a match drop the predecessor first.
      ST_WALK: begin
        if (i_q >= count_q) begin
          res_d     = 1'b1;
          status_d  = match_q ? STAT_OK : STAT_NOT_FOUND;
          removed_d = rem_q;
          state_d   = ST_IDLE;
        end else if (flags.eq[i_idx]) begin
          match_d = 1'b1;
          state_d = ST_SUCC;
          if (i_q != '0) begin
            cmd.op  = CH_DELETE;
            cmd.idx = IDX_W'(i_q - CNT_W'(1));
            i_d     = i_q - CNT_W'(1);
            count_d = count_q - CNT_W'(1);
            rem_d   = rem_q + CNT_W'(1);
          end
        end else begin
          i_d = i_inc;
        end
      end

      // Drop the successor of the matched entry, then move past it.
      ST_SUCC: begin
        if (i_inc < count_q) begin
          cmd.op  = CH_DELETE;
          cmd.idx = IDX_W'(i_inc);
          count_d = count_q - CNT_W'(1);
          rem_d   = rem_q + CNT_W'(1);
        end
        i_d     = i_inc;
        state_d = ST_WALK;
      end

      // Rotate the full row once; the held entries pass the head in order.
      ST_LIST: begin
        cmd.op  = CH_ROTATE;
        value_d = head;
        pos_d   = i_idx;
        last_d  = (i_inc == count_q);
        res_d   = (i_q < count_q);
        i_d     = i_inc;
        if (i_q == CNT_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      i_q     <= '0;
      rem_q   <= '0;
      match_q <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      i_q     <= i_d;
      rem_q   <= rem_d;
      match_q <= match_d;
      done_o  <= res_d;
    end
  end

  // Command word capture and result word register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      op_q   <= operand_i;
    end
    status_o      <= status_d;
    entry_value_o <= value_d;
    position_o    <= pos_d;
    held_o        <= held_d;
    removed_o     <= removed_d;
    last_o        <= last_d;
  end

endmodule

// ===== tb/sorted_list_engine_tb.sv =====
`timescale 1ns / 1ps

module sorted_list_engine_tb;
  import slst_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 2 * DEPTH + 8;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         position;
    logic [CNT_W-1:0]         held;
    logic [CNT_W-1:0]         removed;
    logic                     last;
  } list_reply_t;

  logic                     clk_i     = 1'b0;
  logic                     rst_ni    = 1'b0;
  logic                     start     = 1'b0;
  logic [1:0]               kind_i    = KIND_INSERT;
  logic signed [DATA_W-1:0] operand_i = '0;
  logic                     busy;
  logic                     done_o;
  logic [1:0]               status_o;
  logic signed [DATA_W-1:0] entry_value_o;
  logic [IDX_W-1:0]         position_o;
  logic [CNT_W-1:0]         held_o;
  logic [CNT_W-1:0]         removed_o;
  logic                     last_o;

  // Shadow copy of the sorted store and the replies it predicts.
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int                       shadow_count = 0;
  list_reply_t              pending_replies [$];
  int                       errors = 0;
  int                       stall_cycles = 0;
  bit                       idle_en = 1'b1;

  sorted_list_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .operand_i     (operand_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .entry_value_o (entry_value_o),
    .position_o    (position_o),
    .held_o        (held_o),
    .removed_o     (removed_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void queue_reply(logic [1:0] status, logic signed [DATA_W-1:0] value,
                                      int pos, int held, int removed, bit last);
    list_reply_t r;
    r.status   = status;
    r.value    = value;
    r.position = pos[IDX_W-1:0];
    r.held     = held[CNT_W-1:0];
    r.removed  = removed[CNT_W-1:0];
    r.last     = last;
    pending_replies.push_back(r);
  endfunction

  // Close the gap left by the entry at idx.
  function automatic void drop_entry(int idx);
    int k;
    for (k = idx; k + 1 < shadow_count; k++) shadow_entries[k] = shadow_entries[k + 1];
    shadow_count--;
  endfunction

  // Apply one command to the shadow store and queue the replies it should produce.
  function automatic void predict_command(logic [1:0] kind, logic signed [DATA_W-1:0] x);
    int i;
    int k;
    int n_removed;
    bit matched;
    i = 0;
    n_removed = 0;
    matched = 1'b0;
    case (kind)
      KIND_INSERT: begin
        if (shadow_count >= DEPTH) begin
          queue_reply(STAT_FULL, x, 0, shadow_count, 0, 1'b1);
        end else begin
          while (i < shadow_count && shadow_entries[i] < x) i++;
          for (k = shadow_count; k > i; k--) shadow_entries[k] = shadow_entries[k - 1];
          shadow_entries[i] = x;
          shadow_count++;
          queue_reply(STAT_OK, x, i, shadow_count, 0, 1'b1);
        end
      end
      KIND_REMOVE: begin
        if (shadow_count == 0) begin
          queue_reply(STAT_EMPTY, x, 0, 0, 0, 1'b1);
        end else begin
          while (i < shadow_count && shadow_entries[i] != x) i++;
          if (i >= shadow_count) begin
            queue_reply(STAT_NOT_FOUND, x, 0, shadow_count, 0, 1'b1);
          end else begin
            drop_entry(i);
            queue_reply(STAT_OK, x, i, shadow_count, 1, 1'b1);
          end
        end
      end
      KIND_NEIGHBOUR: begin
        if (shadow_count == 0) begin
          queue_reply(STAT_EMPTY, x, 0, 0, 0, 1'b1);
        end else begin
          // After a match the walk resumes past the deleted successor.
          while (i < shadow_count) begin
            if (shadow_entries[i] == x) begin
              matched = 1'b1;
              if (i > 0) begin
                drop_entry(i - 1);
                i--;
                n_removed++;
              end
              if (i + 1 < shadow_count) begin
                drop_entry(i + 1);
                n_removed++;
              end
            end
            i++;
          end
          queue_reply(matched ? STAT_OK : STAT_NOT_FOUND, x, 0, shadow_count, n_removed,
                      1'b1);
        end
      end
      default: begin
        if (shadow_count == 0) begin
          queue_reply(STAT_EMPTY, '0, 0, 0, 0, 1'b1);
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            queue_reply(STAT_OK, shadow_entries[i], i, shadow_count, 0,
                        i + 1 == shadow_count);
          end
        end
      end
    endcase
  endfunction

  // Present one command word and hold it until the block takes it.
  task automatic send_word(logic [1:0] kind, logic signed [DATA_W-1:0] x);
    while (idle_en && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start     <= 1'b1;
    kind_i    <= kind;
    operand_i <= x;
    do @(posedge clk_i); while (busy);
    predict_command(kind, x);
  endtask

  // Stop sending and wait until every predicted reply has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic compare_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Every reply word is checked against the oldest prediction.
  always @(posedge clk_i) begin : check_replies
    list_reply_t want;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply word: expected none, actual value %0d", $time,
                 entry_value_o);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        compare_field("status", want.status, status_o);
        compare_field("entry_value", want.value, entry_value_o);
        compare_field("position", want.position, position_o);
        compare_field("held", want.held, held_o);
        compare_field("removed", want.removed, removed_o);
        compare_field("last", want.last, last_o);
      end
    end
  end

  // Watchdog on cycles in which no word moves in either direction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("sorted_list_engine regression: fail");
        $finish;
      end
    end
  end

  // List, remove and remove-neighbours on an empty store.
  task automatic test_empty_store();
    send_word(KIND_LIST, 32'sd9);
    send_word(KIND_REMOVE, 32'sd5);
    send_word(KIND_NEIGHBOUR, 32'sd5);
  endtask

  // Extreme operands, a hit and a miss for remove, and a match-free neighbour sweep.
  task automatic test_extremes();
    send_word(KIND_INSERT, 32'sh7fffffff);
    send_word(KIND_INSERT, 32'sh80000000);
    send_word(KIND_INSERT, 32'sd0);
    send_word(KIND_INSERT, -32'sd1);
    send_word(KIND_REMOVE, 32'sd0);
    send_word(KIND_REMOVE, 32'sd7);
    send_word(KIND_NEIGHBOUR, 32'sd7);
  endtask

  // A match in the middle, then two equal entries in a row.
  task automatic test_neighbours();
    send_word(KIND_NEIGHBOUR, -32'sd1);
    send_word(KIND_INSERT, 32'sd3);
    send_word(KIND_INSERT, 32'sd3);
    send_word(KIND_NEIGHBOUR, 32'sd3);
  endtask

  // Fill the store, overflow it once, then list all sixteen entries.
  task automatic test_full_store();
    while (shadow_count < DEPTH) send_word(KIND_INSERT, int'($urandom_range(0, 8)) - 4);
    send_word(KIND_INSERT, 32'sd1);
    send_word(KIND_LIST, 32'sd0);
    wait_drained();
  endtask

  // Random command mix; most removes aim at held values so matches are common.
  task automatic test_random_mix();
    int n;
    int r;
    logic [1:0] kind;
    logic signed [DATA_W-1:0] x;
    for (n = 0; n < 330; n++) begin
      idle_en = !(n >= 100 && n < 200);
      if (n == 250) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 40) kind = KIND_INSERT;
      else if (r < 65) kind = KIND_REMOVE;
      else if (r < 80) kind = KIND_NEIGHBOUR;
      else kind = KIND_LIST;
      if (kind != KIND_INSERT && shadow_count > 0 && $urandom_range(0, 99) < 70) begin
        x = shadow_entries[$urandom_range(0, shadow_count - 1)];
      end else if ($urandom_range(0, 99) < 60) begin
        x = int'($urandom_range(0, 8)) - 4;
      end else begin
        x = $urandom;
      end
      send_word(kind, x);
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_extremes();
    test_neighbours();
    test_full_store();
    test_random_mix();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("sorted_list_engine regression: pass");
    end else begin
      $display("sorted_list_engine regression: fail");
    end
    $finish;
  end

endmodule
